// ===== src/lom_pkg.sv =====
// Package for the limit order matcher.
// Holds the shared types, status codes and controller states; no dependencies.
package lom_pkg;

  typedef enum logic [2:0] {
    ST_REJECTED  = 3'd0,
    ST_FILLED    = 3'd1,
    ST_PARTIAL   = 3'd2,
    ST_NEW       = 3'd3,
    ST_CANCELLED = 3'd4,
    ST_BOOK_FULL = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    TIF_GTC = 2'd0,
    TIF_IOC = 2'd1,
    TIF_FOK = 2'd2,
    TIF_GTD = 2'd3
  } tif_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_WAIT,
    S_DECIDE
  } state_e;

  localparam logic REC_TRADE  = 1'b0;
  localparam logic REC_STATUS = 1'b1;

  typedef struct packed {
    logic               market;
    logic signed [31:0] lim;
  } search_t;

  typedef struct packed {
    logic        dec;
    logic        remove;
    logic [31:0] fill;
  } upd_t;

  typedef struct packed {
    logic               ins;
    logic [31:0]        id;
    logic signed [31:0] price;
    logic [31:0]        rem;
  } ins_t;

  typedef struct packed {
    logic               valid;
    logic [31:0]        id;
    logic signed [31:0] price;
    logic [31:0]        rem;
  } res_t;

endpackage

// ===== src/limit_order_matcher.sv =====
// Limit order matcher top level: order controller, bid and ask cell chains.
// The opposing chain is searched anew before each match decision; orders are
// taken one at a time. A malformed order is rejected without a search.
// Reset empties both tables at once and clears the trade counter.
// Depends on lom_pkg and lom_book.
module limit_order_matcher #(
  parameter int BOOK_ENTRIES = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [31:0]        order_id_i,
  input  logic               side_i,
  input  logic               order_kind_i,
  input  logic               price_given_i,
  input  logic signed [31:0] limit_price_i,
  input  logic [31:0]        quantity_i,
  input  logic [1:0]         time_in_force_i,
  input  logic [15:0]        symbol_code_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               record_kind_o,
  output logic [31:0]        trade_number_o,
  output logic [31:0]        buyer_id_o,
  output logic [31:0]        seller_id_o,
  output logic [15:0]        trade_symbol_o,
  output logic signed [31:0] trade_price_o,
  output logic [31:0]        amount_o,
  output logic [2:0]         final_status_o,
  output logic               last_record_o
);
  import lom_pkg::*;

  localparam int N  = BOOK_ENTRIES;
  localparam int IW = $clog2(N);
  localparam int SW = 32 + IW;
  localparam int CW = $clog2(N + 1);

  state_e             state_q, state_d;
  logic [31:0]        id_q, qty_q, left_q, tc_q;
  logic               sell_q, market_q, fok_q, bad_q;
  logic signed [31:0] lim_q;
  logic [1:0]         tif_q;
  logic [15:0]        sym_q;
  logic [CW-1:0]      cnt_q;

  logic               out_valid_q;
  logic               rk_q, last_q;
  logic [31:0]        tn_q, buy_q, sel_q, amt_q;
  logic [15:0]        tsym_q;
  logic signed [31:0] tpx_q;
  logic [2:0]         st_q;

  search_t       srch;
  upd_t          upd;
  ins_t          ins;
  res_t          bid_best, ask_best, best;
  logic [IW-1:0] bid_idx, ask_idx, best_idx;
  logic [SW-1:0] bid_sum, ask_sum, opp_sum;
  logic          bid_full, ask_full, own_full;

  logic          accept, slot_free, fok_short, matchable, rest;
  logic [31:0]   fill;
  status_e       fin_st;
  logic          load_trade, load_status;
  logic [31:0]   status_amt;

  assign srch = '{market: market_q, lim: lim_q};

  lom_book #(.N(N), .IS_ASK(1'b0)) u_bid (
    .clk_i, .rst_ni, .srch_i(srch),
    .upd_i(sell_q ? upd : upd_t'('0)), .upd_idx_i(best_idx),
    .ins_i(sell_q ? ins_t'('0) : ins),
    .best_o(bid_best), .best_idx_o(bid_idx), .sum_o(bid_sum), .full_o(bid_full)
  );

  lom_book #(.N(N), .IS_ASK(1'b1)) u_ask (
    .clk_i, .rst_ni, .srch_i(srch),
    .upd_i(sell_q ? upd_t'('0) : upd), .upd_idx_i(best_idx),
    .ins_i(sell_q ? ins : ins_t'('0)),
    .best_o(ask_best), .best_idx_o(ask_idx), .sum_o(ask_sum), .full_o(ask_full)
  );

  assign best     = sell_q ? bid_best : ask_best;
  assign best_idx = sell_q ? bid_idx : ask_idx;
  assign opp_sum  = sell_q ? bid_sum : ask_sum;
  assign own_full = sell_q ? ask_full : bid_full;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;
  assign fok_short  = fok_q && (opp_sum < SW'(qty_q));
  assign matchable  = best.valid && (left_q != '0) &&
                      (market_q || (sell_q ? (best.price >= lim_q)
                                           : (best.price <= lim_q)));
  assign fill       = (left_q < best.rem) ? left_q : best.rem;

  always_comb begin
    rest = 1'b0;
    if (left_q == '0) begin
      fin_st = ST_FILLED;
    end else if (market_q || (tif_q == TIF_IOC) || (tif_q == TIF_FOK)) begin
      fin_st = ST_CANCELLED;
    end else if (own_full) begin
      fin_st = ST_BOOK_FULL;
    end else begin
      rest   = 1'b1;
      fin_st = (left_q < qty_q) ? ST_PARTIAL : ST_NEW;
    end
  end

  // Output and book control.
  always_comb begin
    load_trade  = 1'b0;
    load_status = 1'b0;
    status_amt  = left_q;
    upd         = '0;
    ins         = '0;
    case (state_q)
      S_CHECK: begin
        if (bad_q && slot_free) begin
          load_status = 1'b1;
          status_amt  = qty_q;
        end
      end
      S_DECIDE: begin
        if (slot_free) begin
          if (fok_short) begin
            load_status = 1'b1;
            status_amt  = qty_q;
          end else if (matchable) begin
            load_trade = 1'b1;
            upd        = '{dec: 1'b1, remove: (fill == best.rem), fill: fill};
          end else begin
            load_status = 1'b1;
            ins = '{ins: rest, id: id_q, price: lim_q, rem: left_q};
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (accept) state_d = S_CHECK;
      S_CHECK: begin
        if (!bad_q) state_d = S_WAIT;
        else if (slot_free) state_d = S_IDLE;
      end
      S_WAIT:   if (cnt_q == CW'(N - 1)) state_d = S_DECIDE;
      S_DECIDE: begin
        if (load_trade) state_d = S_WAIT;
        else if (load_status) state_d = S_IDLE;
      end
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tc_q        <= '0;
      cnt_q       <= '0;
      fok_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_WAIT) cnt_q <= cnt_q + 1'b1;
      else cnt_q <= '0;
      if (accept) fok_q <= (time_in_force_i == TIF_FOK);
      else if ((state_q == S_DECIDE) && slot_free) fok_q <= 1'b0;
      if (load_trade) tc_q <= tc_q + 1'b1;
      if (load_trade || load_status) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      id_q     <= order_id_i;
      sell_q   <= side_i;
      market_q <= order_kind_i;
      lim_q    <= limit_price_i;
      qty_q    <= quantity_i;
      left_q   <= quantity_i;
      tif_q    <= time_in_force_i;
      sym_q    <= symbol_code_i;
      bad_q    <= (order_kind_i == price_given_i) || (quantity_i == '0);
    end else if (load_trade) begin
      left_q <= left_q - fill;
    end
    if (load_trade) begin
      rk_q   <= REC_TRADE;
      tn_q   <= tc_q;
      buy_q  <= sell_q ? best.id : id_q;
      sel_q  <= sell_q ? id_q : best.id;
      tsym_q <= sym_q;
      tpx_q  <= best.price;
      amt_q  <= fill;
      st_q   <= 3'(ST_REJECTED);
      last_q <= 1'b0;
    end else if (load_status) begin
      rk_q   <= REC_STATUS;
      tn_q   <= '0;
      buy_q  <= '0;
      sel_q  <= '0;
      tsym_q <= '0;
      tpx_q  <= '0;
      amt_q  <= status_amt;
      st_q   <= (bad_q || fok_short) ? 3'(ST_REJECTED) : 3'(fin_st);
      last_q <= 1'b1;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign record_kind_o  = rk_q;
  assign trade_number_o = tn_q;
  assign buyer_id_o     = buy_q;
  assign seller_id_o    = sel_q;
  assign trade_symbol_o = tsym_q;
  assign trade_price_o  = tpx_q;
  assign amount_o       = amt_q;
  assign final_status_o = st_q;
  assign last_record_o  = last_q;

endmodule

// ===== src/lom_cell.sv =====
// One entry of a price table with its stage of the best-price search.
// Depends on lom_pkg.
module lom_cell #(
  parameter int N      = 32,
  parameter int IDX    = 0,
  parameter bit IS_ASK = 1'b0
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lom_pkg::search_t        srch_i,
  input  lom_pkg::upd_t           upd_i,
  input  logic [$clog2(N)-1:0]    upd_idx_i,
  input  lom_pkg::ins_t           ins_i,
  input  logic                    prev_occ_i,
  input  logic                    nxt_occ_i,
  input  logic [31:0]             nxt_id_i,
  input  logic signed [31:0]      nxt_price_i,
  input  logic [31:0]             nxt_rem_i,
  input  lom_pkg::res_t           best_i,
  input  logic [$clog2(N)-1:0]    best_idx_i,
  input  logic [32+$clog2(N)-1:0] sum_i,
  output logic                    occ_o,
  output logic [31:0]             id_o,
  output logic signed [31:0]      price_o,
  output logic [31:0]             rem_o,
  output lom_pkg::res_t           best_o,
  output logic [$clog2(N)-1:0]    best_idx_o,
  output logic [32+$clog2(N)-1:0] sum_o
);
  import lom_pkg::*;

  localparam int IW = $clog2(N);
  localparam int SW = 32 + IW;
  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic               occ_q;
  logic [31:0]        id_q, id_d;
  logic signed [31:0] price_q, price_d;
  logic [31:0]        rem_q, rem_d;
  logic               occ_d;
  logic               take_own, crosses_lim;
  res_t               best_d;
  logic [IW-1:0]      best_idx_d;
  logic [SW-1:0]      sum_d;

  always_comb begin
    occ_d   = occ_q;
    id_d    = id_q;
    price_d = price_q;
    rem_d   = rem_q;
    if (upd_i.remove && (upd_idx_i <= MY_IDX)) begin
      occ_d   = nxt_occ_i;
      id_d    = nxt_id_i;
      price_d = nxt_price_i;
      rem_d   = nxt_rem_i;
    end else if (upd_i.dec && (upd_idx_i == MY_IDX)) begin
      rem_d = rem_q - upd_i.fill;
    end else if (ins_i.ins && !occ_q && prev_occ_i) begin
      occ_d   = 1'b1;
      id_d    = ins_i.id;
      price_d = ins_i.price;
      rem_d   = ins_i.rem;
    end
  end

  always_comb begin
    if (IS_ASK) begin
      take_own    = occ_q && (!best_i.valid || (price_q < best_i.price));
      crosses_lim = srch_i.market || (price_q <= srch_i.lim);
    end else begin
      take_own    = occ_q && (!best_i.valid || (price_q > best_i.price));
      crosses_lim = srch_i.market || (price_q >= srch_i.lim);
    end
    if (take_own) begin
      best_d     = '{valid: 1'b1, id: id_q, price: price_q, rem: rem_q};
      best_idx_d = MY_IDX;
    end else begin
      best_d     = best_i;
      best_idx_d = best_idx_i;
    end
    sum_d = sum_i + ((occ_q && crosses_lim) ? SW'(rem_q) : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q  <= 1'b0;
      best_o <= '0;
    end else begin
      occ_q  <= occ_d;
      best_o <= best_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q       <= id_d;
    price_q    <= price_d;
    rem_q      <= rem_d;
    best_idx_o <= best_idx_d;
    sum_o      <= sum_d;
  end

  assign occ_o   = occ_q;
  assign id_o    = id_q;
  assign price_o = price_q;
  assign rem_o   = rem_q;

endmodule

// ===== src/lom_book.sv =====
// One side of the book: a chain of lom_cell entries kept in arrival order.
// Depends on lom_pkg and lom_cell.
module lom_book #(
  parameter int N      = 32,
  parameter bit IS_ASK = 1'b0
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lom_pkg::search_t        srch_i,
  input  lom_pkg::upd_t           upd_i,
  input  logic [$clog2(N)-1:0]    upd_idx_i,
  input  lom_pkg::ins_t           ins_i,
  output lom_pkg::res_t           best_o,
  output logic [$clog2(N)-1:0]    best_idx_o,
  output logic [32+$clog2(N)-1:0] sum_o,
  output logic                    full_o
);
  import lom_pkg::*;

  localparam int IW = $clog2(N);
  localparam int SW = 32 + IW;

  logic               occ   [N+1];
  logic [31:0]        id    [N+1];
  logic signed [31:0] price [N+1];
  logic [31:0]        rem   [N+1];
  res_t               best  [N+1];
  logic [IW-1:0]      bidx  [N+1];
  logic [SW-1:0]      sum   [N+1];

  assign occ[N]   = 1'b0;
  assign id[N]    = '0;
  assign price[N] = '0;
  assign rem[N]   = '0;
  assign best[0]  = '0;
  assign bidx[0]  = '0;
  assign sum[0]   = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    lom_cell #(.N(N), .IDX(i), .IS_ASK(IS_ASK)) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .srch_i      (srch_i),
      .upd_i       (upd_i),
      .upd_idx_i   (upd_idx_i),
      .ins_i       (ins_i),
      .prev_occ_i  ((i == 0) ? 1'b1 : occ[(i == 0) ? 0 : i-1]),
      .nxt_occ_i   (occ[i+1]),
      .nxt_id_i    (id[i+1]),
      .nxt_price_i (price[i+1]),
      .nxt_rem_i   (rem[i+1]),
      .best_i      (best[i]),
      .best_idx_i  (bidx[i]),
      .sum_i       (sum[i]),
      .occ_o       (occ[i]),
      .id_o        (id[i]),
      .price_o     (price[i]),
      .rem_o       (rem[i]),
      .best_o      (best[i+1]),
      .best_idx_o  (bidx[i+1]),
      .sum_o       (sum[i+1])
    );
  end

  assign best_o     = best[N];
  assign best_idx_o = bidx[N];
  assign sum_o      = sum[N];
  assign full_o     = occ[N-1];

endmodule

// ===== src/lom_checker.sv =====
// Port-level checker for limit_order_matcher, bound to the top level.
// Depends on lom_pkg.
module lom_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        record_kind_o,
  input logic [31:0] trade_number_o,
  input logic [31:0] amount_o,
  input logic [2:0]  final_status_o,
  input logic        last_record_o
);
  import lom_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(amount_o))
    else $error("result item changed while stalled");

  a_trade_fmt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (record_kind_o == REC_TRADE) |->
      !last_record_o && (final_status_o == 3'(ST_REJECTED)) && (amount_o != '0))
    else $error("malformed trade item");

  a_status_fmt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (record_kind_o == REC_STATUS) |->
      last_record_o && (trade_number_o == '0))
    else $error("malformed status item");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second order taken while one is in work");

endmodule

bind limit_order_matcher lom_checker u_lom_checker (.*);

// ===== bench/lom_checker.sv =====
// Checker for the limit order matcher: predicts records from accepted orders.
// Keeps its own bid and ask tables; depends on lom_pkg.
`timescale 1ns / 100ps
module lom_scoreboard #(
  parameter int ENTRIES = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [31:0]        order_id_i,
  input  logic               side_i,
  input  logic               order_kind_i,
  input  logic               price_given_i,
  input  logic signed [31:0] limit_price_i,
  input  logic [31:0]        quantity_i,
  input  logic [1:0]         time_in_force_i,
  input  logic [15:0]        symbol_code_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic               record_kind_i,
  input  logic [31:0]        trade_number_i,
  input  logic [31:0]        buyer_id_i,
  input  logic [31:0]        seller_id_i,
  input  logic [15:0]        trade_symbol_i,
  input  logic signed [31:0] trade_price_i,
  input  logic [31:0]        amount_i,
  input  logic [2:0]         final_status_i,
  input  logic               last_record_i,
  output int                 errors_o,
  output int                 pending_o
);
  import lom_pkg::*;

  typedef struct {
    logic        kind;
    logic [31:0] tnum;
    logic [31:0] buyer;
    logic [31:0] seller;
    logic [15:0] sym;
    logic [31:0] price;
    logic [31:0] amt;
    logic [2:0]  status;
    logic        last;
  } record_t;

  record_t expected_records[$];
  logic [31:0]        bk_id[2][$];
  logic signed [31:0] bk_px[2][$];
  logic [31:0]        bk_rem[2][$];
  logic [31:0] trade_cnt;

  task automatic push_status(logic [31:0] amt, status_e st);
    record_t r;
    r = '{REC_STATUS, 0, 0, 0, 0, 0, amt, st, 1'b1};
    expected_records = {expected_records, r};
  endtask

  function automatic bit crosses(logic signed [31:0] px, bit buy, bit mkt,
                                 logic signed [31:0] lim);
    if (mkt) return 1;
    return buy ? (px <= lim) : (px >= lim);
  endfunction

  task automatic match_order();
    int o, b;
    bit buy, mkt;
    logic [31:0] left, fill;
    logic [63:0] avail;
    record_t r;
    status_e st;
    buy = !side_i;
    mkt = order_kind_i;
    o = buy ? 1 : 0;
    left = quantity_i;
    if ((!mkt && !price_given_i) || (mkt && price_given_i) || quantity_i == 0) begin
      push_status(quantity_i, ST_REJECTED);
      return;
    end
    if (time_in_force_i == TIF_FOK) begin
      avail = '0;
      for (int i = 0; i < bk_px[o].size(); i++)
        if (crosses(bk_px[o][i], buy, mkt, limit_price_i)) avail += bk_rem[o][i];
      if (avail < quantity_i) begin
        push_status(quantity_i, ST_REJECTED);
        return;
      end
    end
    while (left != 0 && bk_px[o].size() > 0) begin
      b = 0;
      for (int i = 0; i < bk_px[o].size(); i++)
        if (buy ? bk_px[o][i] < bk_px[o][b] : bk_px[o][i] > bk_px[o][b]) b = i;
      if (!crosses(bk_px[o][b], buy, mkt, limit_price_i)) break;
      fill = (left < bk_rem[o][b]) ? left : bk_rem[o][b];
      r = '{REC_TRADE, trade_cnt, buy ? order_id_i : bk_id[o][b],
            buy ? bk_id[o][b] : order_id_i, symbol_code_i, bk_px[o][b], fill,
            3'd0, 1'b0};
      expected_records = {expected_records, r};
      trade_cnt++;
      left -= fill;
      bk_rem[o][b] -= fill;
      if (bk_rem[o][b] == 0) begin
        bk_id[o].delete(b);
        bk_px[o].delete(b);
        bk_rem[o].delete(b);
      end
    end
    if (left == 0) st = ST_FILLED;
    else if (time_in_force_i == TIF_IOC || time_in_force_i == TIF_FOK || mkt)
      st = ST_CANCELLED;
    else if (bk_id[1-o].size() >= ENTRIES) st = ST_BOOK_FULL;
    else begin
      bk_id[1-o] = {bk_id[1-o], order_id_i};
      bk_px[1-o] = {bk_px[1-o], limit_price_i};
      bk_rem[1-o] = {bk_rem[1-o], left};
      st = (left < quantity_i) ? ST_PARTIAL : ST_NEW;
    end
    push_status(left, st);
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors_o++;
  endtask

  initial begin
    errors_o = 0;
    pending_o = 0;
    trade_cnt = '0;
  end

  always @(posedge clk_i) begin
    record_t e;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) match_order();
      if (out_valid_i && out_ready_i) begin
        if (expected_records.size() == 0) begin
          report("unexpected record, trade_number", trade_number_i, '0);
        end else begin
          e = expected_records.pop_front();
          if (record_kind_i !== e.kind)
            report("record_kind", 32'(record_kind_i), 32'(e.kind));
          if (trade_number_i !== e.tnum) report("trade_number", trade_number_i, e.tnum);
          if (buyer_id_i !== e.buyer) report("buyer_id", buyer_id_i, e.buyer);
          if (seller_id_i !== e.seller) report("seller_id", seller_id_i, e.seller);
          if (trade_symbol_i !== e.sym)
            report("trade_symbol", 32'(trade_symbol_i), 32'(e.sym));
          if (trade_price_i !== e.price) report("trade_price", trade_price_i, e.price);
          if (amount_i !== e.amt) report("amount", amount_i, e.amt);
          if (final_status_i !== e.status)
            report("final_status", 32'(final_status_i), 32'(e.status));
          if (last_record_i !== e.last)
            report("last_record", 32'(last_record_i), 32'(e.last));
        end
      end
      pending_o = expected_records.size();
    end
  end
endmodule

// ===== bench/tb_limit_order_matcher.sv =====
// Top of the limit order matcher bench: clock, reset, order stimulus, verdict.
// Depends on lom_pkg, limit_order_matcher and lom_scoreboard.
`timescale 1ns / 100ps
module tb_limit_order_matcher;
  import lom_pkg::*;
  localparam int ENTRIES = 32;
  localparam int IDLE_LIMIT = 20000;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic [31:0] order_id_i, quantity_i;
  logic side_i, order_kind_i, price_given_i;
  logic signed [31:0] limit_price_i;
  logic [1:0] time_in_force_i;
  logic [15:0] symbol_code_i;
  logic record_kind_o, last_record_o;
  logic [31:0] trade_number_o, buyer_id_o, seller_id_o, amount_o;
  logic [15:0] trade_symbol_o;
  logic signed [31:0] trade_price_o;
  logic [2:0] final_status_o;
  int errors, pending, idle_cycles, next_id;
  bit hold_sink;

  limit_order_matcher #(.BOOK_ENTRIES(ENTRIES)) dut (.*);

  lom_scoreboard #(.ENTRIES(ENTRIES)) u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .order_id_i, .side_i,
    .order_kind_i, .price_given_i, .limit_price_i, .quantity_i, .time_in_force_i,
    .symbol_code_i, .out_valid_i(out_valid_o), .out_ready_i,
    .record_kind_i(record_kind_o), .trade_number_i(trade_number_o),
    .buyer_id_i(buyer_id_o), .seller_id_i(seller_id_o),
    .trade_symbol_i(trade_symbol_o), .trade_price_i(trade_price_o),
    .amount_i(amount_o), .final_status_i(final_status_o),
    .last_record_i(last_record_o), .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    if ($urandom_range(9) < 7) return $urandom_range(2);
    return $urandom_range(40, 10);
  endfunction

  task automatic send_order(logic [31:0] id, bit sell, bit mkt, bit pg,
                            logic signed [31:0] px, logic [31:0] qty,
                            logic [1:0] tif, logic [15:0] sym, bit gaps);
    if (gaps) repeat (gap_len()) @(negedge clk_i);
    in_valid_i = 1;
    order_id_i = id;
    side_i = sell;
    order_kind_i = mkt;
    price_given_i = pg;
    limit_price_i = px;
    quantity_i = qty;
    time_in_force_i = tif;
    symbol_code_i = sym;
    while (!in_ready_o) @(negedge clk_i);
    @(negedge clk_i);
    in_valid_i = 0;
  endtask

  task automatic send_limit(bit sell, logic signed [31:0] px, logic [31:0] qty,
                            logic [1:0] tif);
    next_id++;
    send_order(next_id, sell, 0, 1, px, qty, tif, 16'($urandom), 1);
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_sink) out_ready_i <= 0;
      else if ($urandom_range(3) == 0) begin
        out_ready_i <= 0;
        repeat (gap_len()) @(negedge clk_i);
      end else out_ready_i <= 1;
    end
  end

  initial begin
    @(posedge rst_ni);
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] q;
    logic signed [31:0] p;
    in_valid_i = 0; out_ready_i = 0; hold_sink = 0;
    order_id_i = 0; side_i = 0; order_kind_i = 0; price_given_i = 0;
    limit_price_i = 0; quantity_i = 0; time_in_force_i = TIF_GTC; symbol_code_i = 0;
    next_id = 100;
    rst_ni = 0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);
    send_order(1, 0, 0, 0, 5, 10, TIF_GTC, 16'hffff, 1);
    send_order(2, 1, 1, 1, 5, 10, TIF_GTC, 0, 1);
    send_order(32'hffffffff, 0, 0, 1, 5, 0, TIF_GTC, 1, 1);
    send_order(3, 1, 1, 0, 0, 5, TIF_IOC, 2, 1);
    send_limit(1, 32'sh7fffffff, 32'hffffffff, TIF_GTC);
    send_limit(1, -32'sd2147483648, 7, TIF_GTD);
    send_limit(1, 50, 20, TIF_GTC);
    send_limit(1, 50, 5, TIF_GTC);
    send_order(4, 0, 0, 1, 60, 1000, TIF_FOK, 3, 1);
    send_order(5, 0, 0, 1, 60, 30, TIF_FOK, 4, 1);
    send_order(6, 0, 0, 1, 40, 10, TIF_IOC, 5, 1);
    send_order(7, 0, 1, 0, 0, 8, TIF_GTC, 16'h1234, 1);
    send_order(8, 1, 0, 1, -32'sd2147483648, 12, TIF_GTC, 6, 1);
    send_order(9, 1, 0, 1, 32'sh7fffffff, 3, TIF_GTC, 7, 1);
    drain();
    hold_sink = 1;
    fork
      begin
        for (int i = 0; i < ENTRIES + 2; i++)
          send_order(200 + i, 0, 0, 1, -32'sd1000 - i, 1 + i, TIF_GTC, 16'(i), 0);
      end
      begin
        repeat (600) @(negedge clk_i);
        hold_sink = 0;
      end
    join
    drain();
    for (int i = 0; i < 52; i++) begin
      q = ($urandom_range(19) == 0) ? $urandom : $urandom_range(40, 1);
      p = ($urandom_range(19) == 0) ? $signed($urandom) : $signed($urandom_range(1, 40) - 1020);
      next_id++;
      case ($urandom_range(9))
        0: send_order($urandom, 1'($urandom), 1'($urandom), 1'($urandom),
                      $signed($urandom), ($urandom_range(3) == 0) ? '0 : q,
                      2'($urandom), 16'($urandom), 1);
        1: send_order(next_id, 1'($urandom), 1, 0, $signed($urandom), q,
                      2'($urandom), 16'($urandom), 1);
        default: send_order(next_id, 1'($urandom), 0, 1, p, q, 2'($urandom),
                            16'($urandom), 1);
      endcase
      if (i == 25) drain();
    end
    drain();
    repeat (4 * (ENTRIES + 1) + 20) @(negedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
